// ===== src/vic_pkg.sv =====
// Shared types and constants for the vertex index compaction block.
`default_nettype none

package vic_pkg;

	// Size of the old-index map.
	localparam int unsigned MAX_VERTICES = 4096;
	localparam int unsigned ADDR_W       = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);

	// Fixed result field widths.
	localparam int unsigned NEW_INDEX_W = 12;
	localparam int unsigned COUNT_W     = 13;

	// Generation mark kept in every map entry.
	localparam int unsigned EPOCH_W = 8;

	typedef enum logic [0:0] {
		OP_REMAP = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		ST_SWEEP = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	typedef struct packed {
		logic [0:0]  op;
		logic [15:0] old_index;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] coord_z;
	} corner_t;

	typedef struct packed {
		logic [NEW_INDEX_W-1:0] new_index;
		logic                   first_use;
		logic [31:0]            out_x;
		logic [31:0]            out_y;
		logic [31:0]            out_z;
		logic [COUNT_W-1:0]     vertex_count;
		logic                   index_error;
	} result_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]     epoch;
		logic [NEW_INDEX_W-1:0] index;
	} map_entry_t;

endpackage

`default_nettype wire

// ===== src/vertex_index_compaction.sv =====
// Top level of the vertex index compaction block: map memory, pipeline and output register.
//
// Usage: face corners enter on the corner channel (corner_valid / corner_ready)
// and one result item leaves for each of them on the result channel
// (result_valid / result_ready), in order. A remap item looks up its old index
// in a 4096-entry synchronous map memory; on a first use it is given the next
// new index and its coordinates are passed on, otherwise the stored index is
// returned. A clear item empties the map and the vertex count.
// An accepted item is registered in the lookup stage with its map read, then
// in the output register that drives result_valid. Throughput: one remap item
// per cycle while result_ready is high and no clearing pass runs, set by the
// single read-modify-write of the map memory with forwarding of the previous
// write; no corner is taken while a clear item waits in the lookup stage.
// Clearing bumps a generation mark held in each map entry, so it costs no
// sweep, except when the mark wraps after 255 clears: then, as after reset, a
// clearing pass writes every entry, one per cycle, while corner_ready is low.
// Reset (arst_n low) empties the pipeline and output register, zeroes the
// count and starts the clearing pass.
// When the receiver holds result_ready low the result is kept in the output
// register; one further item may wait in the lookup stage, after which
// corner_ready falls until the result is taken.
`default_nettype none

module vertex_index_compaction (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 corner_valid,
	output logic                corner_ready,
	input  wire vic_pkg::corner_t corner,
	output logic                result_valid,
	input  wire                 result_ready,
	output vic_pkg::result_t    result
);

	// Map memory: generation mark and new index for each old index.
	vic_pkg::map_entry_t map_mem [vic_pkg::MAX_VERTICES];
	vic_pkg::map_entry_t rd_data_q;

	// Control state.
	vic_pkg::state_t              state_q, state_d;
	logic [vic_pkg::ADDR_W-1:0]   sweep_q;
	logic [vic_pkg::EPOCH_W-1:0]  epoch_q;
	logic [vic_pkg::CNT_W-1:0]    count_q;

	// Lookup stage.
	logic                          valid_s1;
	logic                          op_s1;
	logic                          err_s1;
	logic [vic_pkg::ADDR_W-1:0]    addr_s1;
	logic [31:0]                   x_s1, y_s1, z_s1;
	logic                          fwd_s1;
	logic [vic_pkg::NEW_INDEX_W-1:0] fwd_idx_s1;

	// Output register.
	logic              out_valid_q;
	vic_pkg::result_t  out_q;

	logic                            accept;
	logic                            adv_s1;
	logic                            in_err;
	logic [vic_pkg::ADDR_W-1:0]      in_addr;
	logic                            seen;
	logic [vic_pkg::NEW_INDEX_W-1:0] seen_idx;
	logic                            do_assign;
	logic                            do_clear;
	logic                            wrap_clear;
	logic                            sweep_last;
	logic                            mem_we;
	logic [vic_pkg::ADDR_W-1:0]      mem_waddr;
	vic_pkg::map_entry_t             mem_wdata;
	logic [vic_pkg::CNT_W-1:0]       count_inc;
	vic_pkg::result_t                res_d;

	assign in_addr = corner.old_index[vic_pkg::ADDR_W-1:0];
	assign in_err  = ({16'd0, corner.old_index} >= 32'(vic_pkg::MAX_VERTICES));

	// The lookup stage moves on when the output register is free or being emptied.
	assign adv_s1 = !out_valid_q || result_ready;

	// Nothing enters during a clearing pass, or behind a clear still in the lookup stage.
	assign corner_ready = (state_q == vic_pkg::ST_RUN)
		&& !(valid_s1 && (op_s1 == vic_pkg::OP_CLEAR))
		&& (!valid_s1 || adv_s1);
	assign accept = corner_valid && corner_ready;

	// A hit is an entry written in the current generation, or the entry the
	// previous item wrote in the same cycle as this one was read.
	assign seen     = fwd_s1 || (rd_data_q.epoch == epoch_q);
	assign seen_idx = fwd_s1 ? fwd_idx_s1 : rd_data_q.index;

	assign do_assign = valid_s1 && adv_s1 && (op_s1 == vic_pkg::OP_REMAP)
		&& !err_s1 && !seen;
	assign do_clear   = valid_s1 && adv_s1 && (op_s1 == vic_pkg::OP_CLEAR);
	assign wrap_clear = do_clear && (epoch_q == {vic_pkg::EPOCH_W{1'b1}});
	assign sweep_last = (sweep_q == {vic_pkg::ADDR_W{1'b1}});
	assign count_inc  = count_q + 1'b1;

	// Result of the item in the lookup stage.
	always_comb begin
		res_d = '0;
		if (op_s1 == vic_pkg::OP_REMAP) begin
			res_d.vertex_count = vic_pkg::COUNT_W'(count_q);
			if (err_s1) begin
				res_d.index_error = 1'b1;
			end else if (seen) begin
				res_d.new_index = seen_idx;
			end else begin
				res_d.new_index    = vic_pkg::NEW_INDEX_W'(count_q);
				res_d.first_use    = 1'b1;
				res_d.out_x        = x_s1;
				res_d.out_y        = y_s1;
				res_d.out_z        = z_s1;
				res_d.vertex_count = vic_pkg::COUNT_W'(count_inc);
			end
		end
	end

	// Write port: the clearing pass, or the new mapping of a first use.
	always_comb begin
		if (state_q == vic_pkg::ST_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else begin
			mem_we          = do_assign;
			mem_waddr       = addr_s1;
			mem_wdata.epoch = epoch_q;
			mem_wdata.index = vic_pkg::NEW_INDEX_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_q <= map_mem[in_addr];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vic_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					state_d = vic_pkg::ST_RUN;
				end
			end
			vic_pkg::ST_RUN: begin
				if (wrap_clear) begin
					state_d = vic_pkg::ST_SWEEP;
				end
			end
			default: state_d = vic_pkg::ST_SWEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vic_pkg::ST_SWEEP;
			sweep_q <= '0;
			epoch_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vic_pkg::ST_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_last) begin
					// Swept entries carry mark zero, so live entries start at one.
					epoch_q <= vic_pkg::EPOCH_W'(1);
				end
			end else if (do_clear) begin
				epoch_q <= epoch_q + 1'b1;
				count_q <= '0;
			end else if (do_assign) begin
				count_q <= count_inc;
			end
		end
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= corner.op;
			err_s1     <= in_err;
			addr_s1    <= in_addr;
			x_s1       <= corner.coord_x;
			y_s1       <= corner.coord_y;
			z_s1       <= corner.coord_z;
			fwd_s1     <= do_assign && (addr_s1 == in_addr);
			fwd_idx_s1 <= vic_pkg::NEW_INDEX_W'(count_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the vertex index compaction block.
`timescale 1ns / 1ps

module tb;

	// One face corner waiting to be offered, with the idle cycles to leave
	// before it and a flag that holds it back until every result is in.
	typedef struct {
		vic_pkg::corner_t c;
		int unsigned      gap;
		bit               drain;
	} pending_corner_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             corner_valid = 1'b0;
	logic             result_ready = 1'b0;
	vic_pkg::corner_t corner       = '0;
	logic             corner_ready;
	logic             result_valid;
	vic_pkg::result_t result;

	vertex_index_compaction u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.corner_valid (corner_valid),
		.corner_ready (corner_ready),
		.corner       (corner),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Corners still to be offered, and the results that accepted corners
	// must produce, oldest first.
	pending_corner_t  pending_corners[$];
	vic_pkg::result_t expected_results[$];

	// Our own copy of the renumbering map and the running vertex count.
	bit                              seen_map [vic_pkg::MAX_VERTICES];
	logic [vic_pkg::NEW_INDEX_W-1:0] new_index_map [vic_pkg::MAX_VERTICES];
	logic [vic_pkg::COUNT_W-1:0]     vertices_assigned = '0;

	int unsigned corners_queued   = 0;
	int unsigned clears_queued    = 0;
	int unsigned corners_offered  = 0;
	int unsigned corners_taken    = 0;
	int unsigned results_seen     = 0;
	int unsigned failures         = 0;
	int unsigned first_uses       = 0;
	int unsigned repeat_uses      = 0;
	int unsigned index_errors     = 0;
	int unsigned clears_done      = 0;
	int unsigned peak_count       = 0;

	// Works out the result of one corner and updates the map, exactly as the
	// block should when it accepts that corner.
	function automatic vic_pkg::result_t remap_corner(vic_pkg::corner_t c);
		vic_pkg::result_t             r;
		int unsigned                  idx;
		logic [vic_pkg::ADDR_W-1:0]   slot;
		r    = '0;
		idx  = 32'(c.old_index);
		slot = c.old_index[vic_pkg::ADDR_W-1:0];
		if (c.op == vic_pkg::OP_CLEAR) begin
			foreach (seen_map[i])
				seen_map[i] = 1'b0;
			vertices_assigned = '0;
			clears_done++;
		end else if (idx >= vic_pkg::MAX_VERTICES) begin
			// Out of the table: flagged, the map and the count stay as they are.
			r.vertex_count = vertices_assigned;
			r.index_error  = 1'b1;
			index_errors++;
		end else if (seen_map[slot]) begin
			r.new_index    = new_index_map[slot];
			r.vertex_count = vertices_assigned;
			repeat_uses++;
		end else begin
			seen_map[slot]      = 1'b1;
			new_index_map[slot] = vertices_assigned[vic_pkg::NEW_INDEX_W-1:0];
			r.new_index         = vertices_assigned[vic_pkg::NEW_INDEX_W-1:0];
			vertices_assigned   = vertices_assigned + 1'b1;
			r.first_use         = 1'b1;
			r.out_x             = c.coord_x;
			r.out_y             = c.coord_y;
			r.out_z             = c.coord_z;
			r.vertex_count      = vertices_assigned;
			first_uses++;
			if (32'(vertices_assigned) > peak_count)
				peak_count = 32'(vertices_assigned);
		end
		return r;
	endfunction

	// Sender idling: mostly none, otherwise a short gap or, now and then, a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic bit [31:0] pick_coord();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'h0000_0000;
		if (roll == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic int unsigned pick_table_index();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return vic_pkg::MAX_VERTICES - 1;
		return $urandom_range(0, vic_pkg::MAX_VERTICES - 1);
	endfunction

	function automatic int unsigned pick_outside_index();
		int unsigned roll;
		roll = $urandom_range(0, 4);
		if (roll == 0)
			return vic_pkg::MAX_VERTICES;
		if (roll == 1)
			return 65535;
		return $urandom_range(vic_pkg::MAX_VERTICES, 65535);
	endfunction

	task automatic queue_corner(vic_pkg::op_t op, int unsigned idx, bit [31:0] x,
			bit [31:0] y, bit [31:0] z, bit drain, bit quiet);
		pending_corner_t p;
		p.c.op        = op;
		p.c.old_index = idx[15:0];
		p.c.coord_x   = x;
		p.c.coord_y   = y;
		p.c.coord_z   = z;
		p.gap         = quiet ? 0 : pick_gap();
		p.drain       = drain;
		pending_corners = {pending_corners, p};
		corners_queued++;
		if (op == vic_pkg::OP_CLEAR)
			clears_queued++;
	endtask

	// One mesh: normally a clear, then corners drawn from a small pool of old
	// indices so that repeats are common. A few corners are noise: indices
	// outside the table or a stray clear in the middle of the mesh.
	task automatic queue_mesh(int unsigned n_corners, bit lead_clear, bit drain, bit quiet);
		int unsigned pool[$];
		int unsigned pool_size;
		int unsigned roll;
		bit          hold;
		hold      = drain;
		pool_size = $urandom_range(1, n_corners);
		for (int i = 0; i < pool_size; i++)
			pool = {pool, pick_table_index()};
		if (lead_clear) begin
			queue_corner(vic_pkg::OP_CLEAR, $urandom_range(0, 65535), $urandom, $urandom,
				$urandom, hold, quiet);
			hold = 1'b0;
			if ($urandom_range(0, 7) == 0)
				queue_corner(vic_pkg::OP_CLEAR, $urandom_range(0, 65535), $urandom,
					$urandom, $urandom, 1'b0, quiet);
		end
		for (int i = 0; i < n_corners; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				queue_corner(vic_pkg::OP_REMAP, pick_outside_index(), pick_coord(),
					pick_coord(), pick_coord(), hold, quiet);
			else if (roll < 6)
				queue_corner(vic_pkg::OP_CLEAR, $urandom_range(0, 65535), $urandom,
					$urandom, $urandom, hold, quiet);
			else
				queue_corner(vic_pkg::OP_REMAP, pool[$urandom_range(0, pool_size - 1)],
					pick_coord(), pick_coord(), pick_coord(), hold, quiet);
			hold = 1'b0;
		end
	endtask

	// Sender: offers the next pending corner at the falling edge once the
	// previous one has been taken and its gap has run out. valid is decided
	// in one variable so that it is assigned exactly once per edge.
	pending_corner_t staged_corner;
	bit              staged   = 1'b0;
	int unsigned     gap_left = 0;

	always @(negedge clk) begin : drive_corners
		bit offer;
		offer = corner_valid;
		if (arst_n) begin
			if (corner_valid && corners_taken == corners_offered)
				offer = 1'b0;
			if (!offer) begin
				if (!staged && pending_corners.size() != 0) begin
					staged_corner = pending_corners.pop_front();
					staged        = 1'b1;
					gap_left      = staged_corner.gap;
				end
				if (staged) begin
					if (gap_left != 0) begin
						gap_left--;
					end else if (!staged_corner.drain || expected_results.size() == 0) begin
						corner <= staged_corner.c;
						offer  = 1'b1;
						staged = 1'b0;
						corners_offered++;
					end
				end
			end
		end
		corner_valid <= offer;
	end

	// Receiver: short random stalls, the odd long one, calm stretches with no
	// stall at all, and once a long hold-off so that the block backs up and
	// lowers corner_ready while the sender keeps offering.
	int unsigned stall_left     = 0;
	int unsigned calm_left      = 0;
	bit          long_hold_done = 1'b0;

	always @(negedge clk) begin : drive_ready
		int unsigned roll;
		if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 300) begin
			long_hold_done = 1'b1;
			stall_left     = 150;
			result_ready <= 1'b0;
		end else if (calm_left != 0) begin
			calm_left--;
			result_ready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				result_ready <= 1'b1;
			end else if (roll < 90) begin
				stall_left = $urandom_range(0, 3);
				result_ready <= 1'b0;
			end else if (roll < 95) begin
				stall_left = $urandom_range(8, 30);
				result_ready <= 1'b0;
			end else begin
				calm_left = $urandom_range(30, 120);
				result_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	// Both handshakes are sampled at the rising edge. An accepted corner is
	// run through the predictor at once, so the map always reflects exactly
	// the corners the block has taken.
	always @(posedge clk) begin : watch_ports
		vic_pkg::result_t want;
		vic_pkg::result_t predicted;
		if (arst_n) begin
			if (corner_valid && corner_ready) begin
				predicted        = remap_corner(corner);
				expected_results = {expected_results, predicted};
				corners_taken++;
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no corner waiting for it");
					failures++;
				end else begin
					want = expected_results.pop_front();
					check_field("new_index", 64'(want.new_index), 64'(result.new_index));
					check_field("first_use", 64'(want.first_use), 64'(result.first_use));
					check_field("out_x", 64'(want.out_x), 64'(result.out_x));
					check_field("out_y", 64'(want.out_y), 64'(result.out_y));
					check_field("out_z", 64'(want.out_z), 64'(result.out_z));
					check_field("vertex_count", 64'(want.vertex_count),
						64'(result.vertex_count));
					check_field("index_error", 64'(want.index_error),
						64'(result.index_error));
				end
				results_seen++;
			end
		end
	end

	initial begin : stimulus
		int unsigned roll, size;

		// Directed corners. The map is empty after reset, so the first two
		// are first uses at both ends of the table; then repeats, indices just
		// past and far past the table, back-to-back clears and reuse after a
		// clear. The first corner at index 1234 waits until all earlier results are in.
		queue_corner(vic_pkg::OP_REMAP, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, vic_pkg::MAX_VERTICES - 1, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, 0, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_FFFF,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, vic_pkg::MAX_VERTICES, 32'h1234_5678, 32'h9ABC_DEF0,
			32'h0F0F_F0F0, 1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, vic_pkg::MAX_VERTICES - 1, 32'h0, 32'h0, 32'h0,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, 1, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
			1'b0, 1'b0);
		queue_corner(vic_pkg::OP_CLEAR, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_CLEAR, 0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, vic_pkg::MAX_VERTICES - 1, 32'hDEAD_BEEF,
			32'hCAFE_F00D, 32'h0BAD_F00D, 1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, 0, 32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_FF00,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, vic_pkg::MAX_VERTICES, 32'h0, 32'h0, 32'h0,
			1'b0, 1'b1);
		queue_corner(vic_pkg::OP_REMAP, vic_pkg::MAX_VERTICES - 1, 32'h0, 32'h0, 32'h0,
			1'b0, 1'b0);
		queue_corner(vic_pkg::OP_REMAP, 1234, 32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000,
			1'b1, 1'b0);
		queue_corner(vic_pkg::OP_REMAP, 1234, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
		queue_corner(vic_pkg::OP_CLEAR, 4095, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);

		// Random meshes, mostly small, then short meshes that each open with
		// a clear until there have been enough clears to wrap the block's
		// generation mark at least once.
		while (corners_queued < 1450) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				size = $urandom_range(1, 4);
			else if (roll < 95)
				size = $urandom_range(5, 16);
			else
				size = $urandom_range(17, 80);
			queue_mesh(size, $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0,
				$urandom_range(0, 9) == 0);
		end
		while (clears_queued < 260)
			queue_mesh(1, 1'b1, 1'b0, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_corners.size() != 0 || staged || corner_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d corners: %0d first uses, %0d repeats, %0d out of table,",
			corners_taken, first_uses, repeat_uses, index_errors);
		$display("%0d clears and a peak vertex count of %0d; %0d result items checked.",
			clears_done, peak_count, results_seen);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Safety net in case the block hangs.
	initial begin : watchdog
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/vic_pkg.sv
src/vertex_index_compaction.sv
sim/tb.sv
